FILE: rtl/core/gpr_pkg.sv
// Shared types, command codes and blend helpers for the glyph pixel renderer.
// No dependencies.
package gpr_pkg;

  typedef enum logic [1:0] {
    CMD_WR_BYTE   = 2'd0,
    CMD_WR_RECORD = 2'd1,
    CMD_RENDER    = 2'd2,
    CMD_UNUSED    = 2'd3
  } cmd_t;

  localparam int unsigned REG_FOUR_BIT    = 0;
  localparam int unsigned REG_FIRST_CODE  = 1;
  localparam int unsigned REG_GLYPH_COUNT = 2;
  localparam int unsigned REG_FONT_HEIGHT = 3;
  localparam int unsigned REG_FG_COLOR    = 4;
  localparam int unsigned REG_BG_COLOR    = 5;

  localparam int unsigned RECORD_W = 53;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CFG_DATA_W = 16;

  // Decoded glyph record
  typedef struct packed {
    logic        present;
    logic [7:0]  adv;
    logic [7:0]  ybear;
    logic [7:0]  xbear;
    logic [7:0]  height;
    logic [7:0]  width;
    logic [11:0] offset;
  } glyph_rec_t;

  // Metric fields carried alongside each render beat
  typedef struct packed {
    logic       present;
    logic [7:0] width;
    logic [7:0] height;
    logic [7:0] xbear;
    logic [7:0] ybear;
    logic [7:0] adv;
  } glyph_info_t;

  // One channel: (f*a + b*(15-a) + 7) / 15, numerator below 1024.
  // x/15 = (x*0x889) >> 15 exactly for x < 2^12.
  function automatic logic [5:0] mix_ch(input logic [5:0] f, input logic [5:0] b,
                                        input logic [3:0] a);
    logic [10:0] num;
    logic [22:0] prod;
    num  = 11'(f) * 11'(a) + 11'(b) * (11'd15 - 11'(a)) + 11'd7;
    prod = 23'(num) * 23'h889;
    return prod[20:15];
  endfunction

endpackage

FILE: rtl/core/gpr_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module gpr_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    if (re) rdata <= mem[raddr];
  end
endmodule

FILE: rtl/core/gpr_blend.sv
// Registered per-channel blend of RGB565 colours by coverage, at the end of the pipeline.
// Depends on gpr_pkg.
module gpr_blend (
  input  logic        clk,
  input  logic        en,
  input  logic [3:0]  cov,
  input  logic [15:0] fg,
  input  logic [15:0] bg,
  output logic [3:0]  cov_q,
  output logic [15:0] color
);
  logic [15:0] f, b;
  logic [4:0]  r, bl;
  logic [5:0]  g;
  logic [15:0] mixed;

  assign f = {fg[7:0], fg[15:8]};
  assign b = {bg[7:0], bg[15:8]};
  assign r  = 5'(gpr_pkg::mix_ch({1'b0, f[15:11]}, {1'b0, b[15:11]}, cov));
  assign g  = gpr_pkg::mix_ch(f[10:5], b[10:5], cov);
  assign bl = 5'(gpr_pkg::mix_ch({1'b0, f[4:0]}, {1'b0, b[4:0]}, cov));
  assign mixed = {r, g, bl};

  always_ff @(posedge clk) begin
    if (en) begin
      cov_q <= cov;
      if (cov == 4'd0)       color <= bg;
      else if (cov == 4'd15) color <= fg;
      else                   color <= {mixed[7:0], mixed[15:8]};
    end
  end
endmodule

FILE: rtl/core/glyph_pixel_render_blend.sv
// Glyph pixel renderer: one beat per cycle while the output is not stalled.
// Stages: record read, index multiply, bitmap address, bitmap read, pixel pick and blend.
// Throughput one beat per clock; the whole pipe advances together and holds while
// the output beat waits on m_tready. Bitmap writes ride the pipe to the read stage.
// Synchronous reset clears valid bits and loads config register defaults; glyph and bitmap
// stores are not cleared and must be written before use. Uses gpr_pkg, gpr_ram, gpr_blend.
module glyph_pixel_render_blend #(
  parameter int unsigned BITMAP_DEPTH = 4096,
  parameter int unsigned GLYPH_SLOTS  = 256
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         cfg_we,
  input  logic [2:0]   cfg_index,
  input  logic [15:0]  cfg_data,
  input  logic         s_tvalid,
  output logic         s_tready,
  // tdata: command[1:0] address[13:2] byte_data[21:14] record_word[74:22]
  //        char_code[82:75] pixel_x[91:83] pixel_y[100:92], zero fill to 103
  input  logic [103:0] s_tdata,
  output logic         m_tvalid,
  input  logic         m_tready,
  // tdata: glyph_present[0] coverage[4:1] color[20:5] glyph_width[28:21]
  //        glyph_height[36:29] x_bearing[44:37] y_bearing[52:45] advance[60:53]
  output logic [63:0]  m_tdata
);
  localparam int unsigned BA_W = (BITMAP_DEPTH > 1) ? $clog2(BITMAP_DEPTH) : 1;
  localparam int unsigned SL_W = (GLYPH_SLOTS > 1) ? $clog2(GLYPH_SLOTS) : 1;
  localparam int unsigned NS = 5;

  logic        four_bit;
  logic [7:0]  first_code, font_height;
  logic [8:0]  glyph_count;
  logic [15:0] fg_color, bg_color;

  always_ff @(posedge clk) begin
    if (rst) begin
      four_bit <= 1'b0; first_code <= 8'd32; glyph_count <= 9'd0;
      font_height <= 8'd16; fg_color <= 16'hFFFF; bg_color <= 16'h0000;
    end else if (cfg_we) begin
      case (cfg_index)
        3'(gpr_pkg::REG_FOUR_BIT):    four_bit    <= cfg_data[0];
        3'(gpr_pkg::REG_FIRST_CODE):  first_code  <= cfg_data[7:0];
        3'(gpr_pkg::REG_GLYPH_COUNT): glyph_count <= cfg_data[8:0];
        3'(gpr_pkg::REG_FONT_HEIGHT): font_height <= cfg_data[7:0];
        3'(gpr_pkg::REG_FG_COLOR):    fg_color    <= cfg_data;
        3'(gpr_pkg::REG_BG_COLOR):    bg_color    <= cfg_data;
        default: ;
      endcase
    end
  end

  // Input fields
  gpr_pkg::cmd_t in_cmd;
  logic [11:0] in_addr;
  logic [7:0]  in_byte, in_code;
  logic [52:0] in_rec;
  logic signed [8:0] in_px, in_py;
  assign in_cmd  = gpr_pkg::cmd_t'(s_tdata[1:0]);
  assign in_addr = s_tdata[13:2];
  assign in_byte = s_tdata[21:14];
  assign in_rec  = s_tdata[74:22];
  assign in_code = s_tdata[82:75];
  assign in_px   = s_tdata[91:83];
  assign in_py   = s_tdata[100:92];

  // Pipe advances when the output slot is free or being drained
  logic adv_en, acc;
  logic [NS-1:0] v;
  assign adv_en   = !v[NS-1] || m_tready;
  assign s_tready = adv_en;
  assign acc      = s_tvalid && s_tready;

  // Stage 0: slot compute and record read
  logic [8:0] slot;
  logic       in_range, rd_rec;
  assign slot     = 9'(in_code) - 9'(first_code);
  assign in_range = (in_code >= first_code) && ({1'b0, slot} < 10'(glyph_count))
                    && (slot < 9'(GLYPH_SLOTS));
  assign rd_rec   = acc && in_cmd == gpr_pkg::CMD_RENDER;

  logic rec_we, bm_we;
  assign rec_we = acc && in_cmd == gpr_pkg::CMD_WR_RECORD && 32'(in_addr) < GLYPH_SLOTS;
  assign bm_we  = acc && in_cmd == gpr_pkg::CMD_WR_BYTE && 32'(in_addr) < BITMAP_DEPTH;

  // Bitmap writes travel three stages so they reach the RAM at the edge where
  // the bitmap is read; renders then see bytes strictly in beat order
  logic [2:0]            bw_v;
  logic [2:0][BA_W-1:0]  bw_addr;
  logic [2:0][7:0]       bw_data;
  always_ff @(posedge clk) begin
    if (rst) bw_v <= '0;
    else if (adv_en) bw_v <= {bw_v[1:0], bm_we};
  end
  always_ff @(posedge clk) begin
    if (adv_en) begin
      bw_addr <= {bw_addr[1:0], BA_W'(in_addr)};
      bw_data <= {bw_data[1:0], in_byte};
    end
  end

  logic [52:0] rec_q;
  gpr_ram #(.WIDTH(gpr_pkg::RECORD_W), .DEPTH(GLYPH_SLOTS)) u_rec (
    .clk(clk), .we(rec_we), .waddr(SL_W'(in_addr)), .wdata(in_rec),
    .re(adv_en), .raddr(SL_W'(slot)), .rdata(rec_q));

  logic       s1_hit;
  logic [7:0] s1_px, s1_py;
  logic       s1_pin;
  always_ff @(posedge clk) begin
    if (adv_en) begin
      s1_hit <= in_range;
      s1_pin <= !in_px[8] && !in_py[8];
      s1_px  <= in_px[7:0];
      s1_py  <= in_py[7:0];
    end
  end

  // Stage 1: decode record, multiply row index
  gpr_pkg::glyph_rec_t rec;
  assign rec = gpr_pkg::glyph_rec_t'(rec_q);
  logic present1;
  assign present1 = s1_hit && rec.present;

  gpr_pkg::glyph_info_t s2_info;
  logic [15:0] s2_n;
  logic [11:0] s2_off;
  logic        s2_inbox;
  always_ff @(posedge clk) begin
    if (adv_en) begin
      s2_info.present <= present1;
      s2_info.width   <= present1 ? rec.width : 8'd0;
      s2_info.height  <= present1 ? rec.height : 8'd0;
      s2_info.xbear   <= present1 ? rec.xbear : 8'd0;
      s2_info.ybear   <= present1 ? rec.ybear : 8'd0;
      s2_info.adv     <= present1 ? rec.adv : {2'b00, font_height[7:2]};
      s2_inbox <= present1 && s1_pin && s1_px < rec.width && s1_py < rec.height;
      s2_n     <= 16'(s1_py) * 16'(rec.width) + 16'(s1_px);
      s2_off   <= rec.offset;
    end
  end

  // Stage 2: bitmap byte address
  logic [16:0] baddr;
  assign baddr = four_bit ? 17'(s2_off) + 17'(s2_n[15:1]) : 17'(s2_off) + 17'(s2_n[15:3]);
  gpr_pkg::glyph_info_t s3_info;
  logic [16:0] s3_addr;
  logic [2:0]  s3_sel;
  logic        s3_inbox, s3_mode;
  always_ff @(posedge clk) begin
    if (adv_en) begin
      s3_info  <= s2_info;
      s3_addr  <= baddr;
      s3_sel   <= s2_n[2:0];
      s3_inbox <= s2_inbox;
      s3_mode  <= four_bit;
    end
  end

  // Stage 3: bitmap read
  logic [7:0] bm_q;
  gpr_ram #(.WIDTH(8), .DEPTH(BITMAP_DEPTH)) u_bm (
    .clk(clk), .we(bw_v[2] && adv_en), .waddr(bw_addr[2]), .wdata(bw_data[2]),
    .re(adv_en), .raddr(BA_W'(s3_addr)), .rdata(bm_q));

  gpr_pkg::glyph_info_t s4_info;
  logic [2:0] s4_sel;
  logic       s4_ok, s4_mode;
  always_ff @(posedge clk) begin
    if (adv_en) begin
      s4_info <= s3_info;
      s4_sel  <= s3_sel;
      s4_mode <= s3_mode;
      s4_ok   <= s3_inbox && 32'(s3_addr) < BITMAP_DEPTH;
    end
  end

  // Stage 4: pixel pick
  logic [3:0] cov4;
  always_comb begin
    cov4 = 4'd0;
    if (s4_ok) begin
      if (s4_mode) cov4 = s4_sel[0] ? bm_q[3:0] : bm_q[7:4];
      else         cov4 = bm_q[3'd7 - s4_sel] ? 4'd15 : 4'd0;
    end
  end

  gpr_pkg::glyph_info_t s5_info;
  logic [3:0]  cov_q;
  logic [15:0] color_q;
  gpr_blend u_blend (.clk(clk), .en(adv_en), .cov(cov4), .fg(fg_color), .bg(bg_color),
                     .cov_q(cov_q), .color(color_q));
  always_ff @(posedge clk) begin
    if (adv_en) s5_info <= s4_info;
  end

  // Valid bits of render beats
  always_ff @(posedge clk) begin
    if (rst) v <= '0;
    else if (adv_en) v <= {v[NS-2:0], rd_rec};
  end

  assign m_tvalid = v[NS-1];
  assign m_tdata  = {3'b000, s5_info.adv, s5_info.ybear, s5_info.xbear,
                     s5_info.height, s5_info.width, color_q, cov_q, s5_info.present};

`ifndef SYNTHESIS
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("output beat changed under stall");
  a_absent_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tdata[0] |-> m_tdata[4:1] == 4'd0)
    else $error("coverage on missing glyph");
  a_cov_bg: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[4:1] == 4'd0 |-> m_tdata[20:5] == bg_color)
    else $error("zero coverage not background");
`endif
endmodule

FILE: sim/glyph_pixel_render_blend_tb.sv
// Testbench for glyph_pixel_render_blend: loads glyphs and bitmaps, renders
// pixels under several register settings and checks every result beat.
// Depends on gpr_pkg and the glyph_pixel_render_blend RTL.
module glyph_pixel_render_blend_tb;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [7:0] adv;
    logic [7:0] ybear;
    logic [7:0] xbear;
    logic [7:0] height;
    logic [7:0] width;
    logic [15:0] color;
    logic [3:0] cov;
    logic present;
  } pixel_res_t;

  class pixel_scoreboard;
    logic [7:0] bitmap[4096];
    logic [52:0] records[256];
    bit four_bit;
    int unsigned first_code, glyph_count, font_height;
    logic [15:0] fg, bg;
    pixel_res_t pending[$];
    int errors;

    function new();
      four_bit = 0; first_code = 32; glyph_count = 0; font_height = 16;
      fg = 16'hFFFF; bg = 0; errors = 0;
    endfunction

    function void set_reg(int unsigned idx, logic [15:0] v);
      case (idx)
        gpr_pkg::REG_FOUR_BIT:    four_bit = v[0];
        gpr_pkg::REG_FIRST_CODE:  first_code = 32'(v[7:0]);
        gpr_pkg::REG_GLYPH_COUNT: glyph_count = 32'(v[8:0]);
        gpr_pkg::REG_FONT_HEIGHT: font_height = 32'(v[7:0]);
        gpr_pkg::REG_FG_COLOR:    fg = v;
        gpr_pkg::REG_BG_COLOR:    bg = v;
        default: ;
      endcase
    endfunction

    function logic [5:0] chan(int unsigned f, int unsigned b, int unsigned a);
      return 6'((f * a + b * (15 - a) + 7) / 15);
    endfunction

    function logic [15:0] shade(logic [3:0] a);
      logic [15:0] f, b, r;
      logic [5:0] cr, cg, cb;
      if (a == 0) return bg;
      if (a == 15) return fg;
      f = {fg[7:0], fg[15:8]};
      b = {bg[7:0], bg[15:8]};
      cr = chan(32'(f[15:11]), 32'(b[15:11]), 32'(a));
      cg = chan(32'(f[10:5]), 32'(b[10:5]), 32'(a));
      cb = chan(32'(f[4:0]), 32'(b[4:0]), 32'(a));
      r = {cr[4:0], cg, cb[4:0]};
      return {r[7:0], r[15:8]};
    endfunction

    function void note_beat(gpr_pkg::cmd_t cmd, logic [11:0] addr, logic [7:0] bdata,
                            logic [52:0] rec, logic [7:0] code,
                            logic signed [8:0] px, logic signed [8:0] py);
      pixel_res_t e;
      logic [52:0] g;
      int unsigned slot, n, a, byt;
      if (cmd == gpr_pkg::CMD_WR_BYTE) bitmap[addr] = bdata;
      else if (cmd == gpr_pkg::CMD_WR_RECORD) begin
        if (addr < 256) records[addr] = rec;
      end else if (cmd == gpr_pkg::CMD_RENDER) begin
        e = '0;
        e.adv = 8'(font_height / 4);
        e.color = bg;
        if (code >= first_code && code < first_code + glyph_count) begin
          slot = 32'(code) - first_code;
          g = records[slot];
          if (g[52]) begin
            e.present = 1; e.width = g[19:12]; e.height = g[27:20];
            e.xbear = g[35:28]; e.ybear = g[43:36]; e.adv = g[51:44];
            if (px >= 0 && py >= 0 && px < e.width && py < e.height) begin
              n = 32'(py[7:0]) * 32'(e.width) + 32'(px[7:0]);
              if (four_bit) begin
                a = 32'(g[11:0]) + n / 2;
                byt = (a < 4096) ? 32'(bitmap[a]) : 0;
                e.cov = n[0] ? byt[3:0] : byt[7:4];
              end else begin
                a = 32'(g[11:0]) + n / 8;
                byt = (a < 4096) ? 32'(bitmap[a]) : 0;
                e.cov = byt[7 - n % 8] ? 4'd15 : 4'd0;
              end
            end
            e.color = shade(e.cov);
          end
        end
        pending.push_back(e);
      end
    endfunction

    function void check_beat(pixel_res_t got);
      pixel_res_t e;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result %h", $time, got);
        errors++;
        return;
      end
      e = pending.pop_front();
      if (got !== e) begin
        errors++;
        if (got.present !== e.present) $display("%0t: present exp %0d got %0d", $time,
          e.present, got.present);
        if (got.cov !== e.cov) $display("%0t: coverage exp %0d got %0d", $time, e.cov, got.cov);
        if (got.color !== e.color) $display("%0t: color exp %h got %h", $time, e.color,
          got.color);
        if (got.width !== e.width) $display("%0t: width exp %0d got %0d", $time, e.width,
          got.width);
        if (got.height !== e.height) $display("%0t: height exp %0d got %0d", $time,
          e.height, got.height);
        if (got.xbear !== e.xbear) $display("%0t: xbear exp %h got %h", $time, e.xbear,
          got.xbear);
        if (got.ybear !== e.ybear) $display("%0t: ybear exp %h got %h", $time, e.ybear,
          got.ybear);
        if (got.adv !== e.adv) $display("%0t: advance exp %0d got %0d", $time, e.adv, got.adv);
      end
    endfunction
  endclass

  logic clk, rst, cfg_we, s_tvalid, s_tready, m_tvalid, m_tready;
  logic [2:0] cfg_index;
  logic [15:0] cfg_data;
  logic [103:0] s_tdata;
  logic [63:0] m_tdata;
  pixel_scoreboard sb;
  bit calm;
  bit written[4096];
  int unsigned live_slots[$];

  glyph_pixel_render_blend u_dut (.*);

  initial begin
    clk = 0;
    forever #10 clk = ~clk;
  end

  initial begin
    #100ms;
    $display("FAIL glyph_pixel_render_blend");
    $finish;
  end

  // receiver with random stall bursts
  initial begin
    int unsigned k;
    m_tready = 0;
    @(posedge clk iff !rst);
    forever begin
      if (!calm && $urandom_range(0, 3) == 0) begin
        m_tready <= 0;
        k = $urandom_range(1, 17);
        repeat (k) @(posedge clk);
      end
      m_tready <= 1;
      k = $urandom_range(1, 30);
      repeat (k) begin
        @(posedge clk);
        if (m_tvalid && m_tready) sb.check_beat(pixel_res_t'(m_tdata[60:0]));
      end
    end
  end

  // s_tvalid stays high after the beat; an idle gap in the next send, drain or the end clears it
  task automatic send(gpr_pkg::cmd_t cmd, logic [11:0] addr, logic [7:0] bdata,
                      logic [52:0] rec, logic [7:0] code,
                      logic signed [8:0] px, logic signed [8:0] py);
    int unsigned k;
    if (!calm && $urandom_range(0, 9) == 0) begin
      s_tvalid <= 0;
      k = $urandom_range(1, 17);
      repeat (k) @(posedge clk);
    end
    s_tvalid <= 1;
    s_tdata <= {3'b0, py, px, code, rec, bdata, addr, cmd};
    @(posedge clk iff s_tready);
    sb.note_beat(cmd, addr, bdata, rec, code, px, py);
    if (cmd == gpr_pkg::CMD_WR_BYTE) written[addr] = 1;
  endtask

  task automatic drain();
    s_tvalid <= 0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  task automatic write_reg(int unsigned idx, logic [15:0] v);
    cfg_we <= 1; cfg_index <= 3'(idx); cfg_data <= v;
    @(posedge clk);
    sb.set_reg(idx, v);
    cfg_we <= 0;
    @(posedge clk);
  endtask

  // glyph whose bitmap lies wholly in written bytes near the bottom of the store
  task automatic load_glyph(int unsigned slot, bit present, int unsigned maxw,
                            int unsigned maxh);
    logic [52:0] rec;
    int unsigned w, h, off, len, i;
    w = $urandom_range(1, maxw);
    h = $urandom_range(1, maxh);
    len = (w * h + 1) / 2 + 1;
    off = $urandom_range(0, 319 - len);
    for (i = 0; i < len; i++)
      if (!written[off + i]) send(gpr_pkg::CMD_WR_BYTE, 12'(off + i), 8'($urandom),
                                  '0, '0, '0, '0);
    rec = {present, 8'($urandom), 8'($urandom), 8'($urandom), 8'(h), 8'(w), 12'(off)};
    send(gpr_pkg::CMD_WR_RECORD, 12'(slot), '0, rec, '0, '0, '0);
    if (present) live_slots.push_back(slot);
  endtask

  task automatic random_phase(int unsigned items);
    int unsigned i, sel, slot;
    logic [52:0] g;
    for (i = 0; i < items; i++) begin
      sel = $urandom_range(0, 99);
      if (sel < 5) send(gpr_pkg::CMD_WR_BYTE, 12'($urandom), 8'($urandom), '0, '0, '0, '0);
      else if (sel < 8) send(gpr_pkg::CMD_UNUSED, 12'($urandom), 8'($urandom),
        53'({$urandom, $urandom}), 8'($urandom), 9'($urandom), 9'($urandom));
      else if (sel < 85 && live_slots.size() > 0) begin
        slot = live_slots[$urandom_range(0, live_slots.size() - 1)];
        g = sb.records[slot];
        send(gpr_pkg::CMD_RENDER, 12'($urandom), 8'($urandom), 53'({$urandom, $urandom}),
             8'(sb.first_code + slot),
             9'($urandom_range(0, g[19:12])) - 9'($urandom_range(0, 7) == 0),
             9'($urandom_range(0, g[27:20])) - 9'($urandom_range(0, 7) == 0));
      end else send(gpr_pkg::CMD_RENDER, 12'($urandom), 8'($urandom),
                    53'({$urandom, $urandom}), 8'($urandom), 9'($urandom), 9'($urandom));
    end
  endtask

  initial begin
    int unsigned i;
    sb = new();
    calm = 0;
    rst = 1; cfg_we = 0; cfg_index = 0; cfg_data = 0; s_tvalid = 0; s_tdata = '0;
    repeat (9) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // every slot gets a record so that any in-range code reads a written slot
    write_reg(gpr_pkg::REG_GLYPH_COUNT, 16'd256);
    write_reg(gpr_pkg::REG_FIRST_CODE, 16'd0);
    write_reg(gpr_pkg::REG_FOUR_BIT, 16'd0);
    for (i = 0; i < 256; i++)
      load_glyph(i, $urandom_range(0, 4) != 0, i < 4 ? 255 : 12, i < 4 ? 2 : 12);
    send(gpr_pkg::CMD_WR_BYTE, 12'hFFF, 8'hA5, '0, '0, '0, '0);
    send(gpr_pkg::CMD_WR_RECORD, 12'hFFF, '0, '1, '0, '0, '0);  // slot beyond the table
    // bitmap tail past the end of the store reads zero
    send(gpr_pkg::CMD_WR_RECORD, 12'd5, '0,
         {1'b1, 8'd3, 8'h80, 8'h7F, 8'd8, 8'd255, 12'hFFF}, '0, '0, '0);
    live_slots.push_back(5);
    // directed renders: box corners, out of box, extremes of x and y, missing codes
    send(gpr_pkg::CMD_RENDER, '0, '0, '0, 8'd5, 9'h000, 9'h000);
    send(gpr_pkg::CMD_RENDER, '0, '0, '0, 8'd5, 9'h0FE, 9'h007);
    send(gpr_pkg::CMD_RENDER, '0, '0, '0, 8'd5, 9'h0FF, 9'h000);
    send(gpr_pkg::CMD_RENDER, '0, '0, '0, 8'd5, 9'h100, 9'h000);
    send(gpr_pkg::CMD_RENDER, '0, '0, '0, 8'd5, 9'h000, 9'h1FF);
    send(gpr_pkg::CMD_RENDER, '0, '0, '0, 8'd5, 9'h000, 9'h008);
    send(gpr_pkg::CMD_RENDER, '0, '0, '0, 8'd255, 9'h0FF, 9'h0FF);
    drain();
    write_reg(gpr_pkg::REG_GLYPH_COUNT, 16'd0);
    send(gpr_pkg::CMD_RENDER, '0, '0, '0, 8'd0, 9'h000, 9'h000);
    drain();
    write_reg(gpr_pkg::REG_FIRST_CODE, 16'd255);
    write_reg(gpr_pkg::REG_GLYPH_COUNT, 16'd1);
    write_reg(gpr_pkg::REG_FONT_HEIGHT, 16'd255);
    send(gpr_pkg::CMD_RENDER, '0, '0, '0, 8'd255, 9'h000, 9'h000);
    send(gpr_pkg::CMD_RENDER, '0, '0, '0, 8'd254, 9'h000, 9'h000);
    drain();

    write_reg(gpr_pkg::REG_FIRST_CODE, 16'd0);
    write_reg(gpr_pkg::REG_GLYPH_COUNT, 16'd256);
    write_reg(gpr_pkg::REG_FONT_HEIGHT, 16'd0);
    write_reg(gpr_pkg::REG_FG_COLOR, 16'h1234);
    write_reg(gpr_pkg::REG_BG_COLOR, 16'hFEDC);
    random_phase(250);
    drain();  // sender holds until every result is back
    write_reg(gpr_pkg::REG_FOUR_BIT, 16'd1);
    write_reg(gpr_pkg::REG_FG_COLOR, 16'($urandom));
    write_reg(gpr_pkg::REG_BG_COLOR, 16'($urandom));
    random_phase(250);
    drain();
    write_reg(gpr_pkg::REG_FIRST_CODE, 16'd100);
    write_reg(gpr_pkg::REG_GLYPH_COUNT, 16'd200);
    write_reg(gpr_pkg::REG_FG_COLOR, 16'h0000);
    write_reg(gpr_pkg::REG_BG_COLOR, 16'hFFFF);
    for (i = 0; i < 200; i++)
      send(gpr_pkg::CMD_RENDER, '0, '0, '0, 8'($urandom), 9'($urandom_range(0, 12)),
           9'($urandom_range(0, 12)));
    drain();
    write_reg(gpr_pkg::REG_FOUR_BIT, 16'd0);
    write_reg(gpr_pkg::REG_FIRST_CODE, 16'd0);
    write_reg(gpr_pkg::REG_GLYPH_COUNT, 16'd256);
    write_reg(gpr_pkg::REG_FONT_HEIGHT, 16'($urandom));
    calm = 1;
    random_phase(150);

    s_tvalid <= 0;
    for (i = 0; i < 100000 && sb.pending.size() != 0; i++) @(posedge clk);
    repeat (20) @(posedge clk);
    if (sb.pending.size() == 0 && sb.errors == 0) $display("PASS glyph_pixel_render_blend");
    else $display("FAIL glyph_pixel_render_blend");
    $finish;
  end
endmodule
